/* rtl/core/clr_pkg.sv */
// ----------------------------------------------------------------------------
// clr_pkg
// Shared widths, command codes and the pixel record for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clr_pkg;

    localparam int COORD_W = 16;   // row / column coordinate width
    localparam int SPAN_W  = 17;   // span, error and step count width
    localparam int INDEX_W = 20;   // frame index width
    localparam int COLOR_W = 32;   // color word width

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // one pixel leaving the walk stage
    typedef struct packed {
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col;
        logic                      last;
        logic                      idle;
    } t_pixel;

endpackage

`default_nettype wire

/* rtl/core/clr_walk.sv */
// ----------------------------------------------------------------------------
// clr_walk
// Line setup and one Bresenham step per beat; registers the produced pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_walk
    import clr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_cmd,
    input  wire logic signed [COORD_W-1:0] i_src_row,
    input  wire logic signed [COORD_W-1:0] i_src_col,
    input  wire logic signed [COORD_W-1:0] i_dst_row,
    input  wire logic signed [COORD_W-1:0] i_dst_col,
    output t_pixel                         o_pix
);

    logic signed [COORD_W-1:0] r_cur_row, n_cur_row;
    logic signed [COORD_W-1:0] r_cur_col, n_cur_col;
    logic [SPAN_W-1:0]         r_error_acc, n_error_acc;
    logic [SPAN_W-1:0]         r_major_span, n_major_span;
    logic [SPAN_W-1:0]         r_minor_span, n_minor_span;
    logic [SPAN_W-1:0]         r_steps_left, n_steps_left;
    logic                      r_major_is_col, n_major_is_col;
    logic                      r_row_dir_neg, n_row_dir_neg;
    logic                      r_col_dir_neg, n_col_dir_neg;
    logic                      r_line_active, n_line_active;
    t_pixel                    r_pix, n_pix;

    // load setup
    logic signed [SPAN_W-1:0] dr, dc;
    logic [SPAN_W-1:0]        ar, ac;
    logic                     ld_col_major;
    // step
    logic [SPAN_W:0]           err_sum;
    logic                      minor_move;
    logic signed [COORD_W-1:0] row_inc, col_inc;
    logic [SPAN_W-1:0]         steps_dec;

    always_comb begin
        dr = SPAN_W'(i_dst_row) - SPAN_W'(i_src_row);
        dc = SPAN_W'(i_dst_col) - SPAN_W'(i_src_col);
        ar = dr[SPAN_W-1] ? SPAN_W'(-dr) : SPAN_W'(dr);
        ac = dc[SPAN_W-1] ? SPAN_W'(-dc) : SPAN_W'(dc);
        ld_col_major = ac > ar;

        err_sum    = {1'b0, r_error_acc} + {1'b0, r_minor_span};
        minor_move = err_sum >= {1'b0, r_major_span};
        row_inc    = r_row_dir_neg ? -COORD_W'(1) : COORD_W'(1);
        col_inc    = r_col_dir_neg ? -COORD_W'(1) : COORD_W'(1);
        steps_dec  = r_steps_left - SPAN_W'(1);

        n_cur_row      = r_cur_row;
        n_cur_col      = r_cur_col;
        n_error_acc    = r_error_acc;
        n_major_span   = r_major_span;
        n_minor_span   = r_minor_span;
        n_steps_left   = r_steps_left;
        n_major_is_col = r_major_is_col;
        n_row_dir_neg  = r_row_dir_neg;
        n_col_dir_neg  = r_col_dir_neg;
        n_line_active  = r_line_active;
        n_pix          = '0;

        if (i_cmd == CMD_LOAD) begin
            n_row_dir_neg  = dr <= 0;
            n_col_dir_neg  = dc <= 0;
            n_major_is_col = ld_col_major;
            n_major_span   = ld_col_major ? ac : ar;
            n_minor_span   = ld_col_major ? ar : ac;
            n_error_acc    = n_major_span >> 1;
            n_steps_left   = n_major_span;
            n_cur_row      = i_src_row;
            n_cur_col      = i_src_col;
            n_line_active  = n_major_span != '0;
            n_pix.row      = i_src_row;
            n_pix.col      = i_src_col;
            n_pix.last     = !n_line_active;
        end else if (!r_line_active) begin
            n_pix.idle = 1'b1;
        end else begin
            n_error_acc = minor_move ? SPAN_W'(err_sum - {1'b0, r_major_span})
                                     : err_sum[SPAN_W-1:0];
            if (r_major_is_col) begin
                n_cur_col = r_cur_col + col_inc;
                if (minor_move) n_cur_row = r_cur_row + row_inc;
            end else begin
                n_cur_row = r_cur_row + row_inc;
                if (minor_move) n_cur_col = r_cur_col + col_inc;
            end
            n_steps_left  = steps_dec;
            n_line_active = steps_dec != '0;
            n_pix.row     = n_cur_row;
            n_pix.col     = n_cur_col;
            n_pix.last    = !n_line_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row      <= '0;
            r_cur_col      <= '0;
            r_error_acc    <= '0;
            r_major_span   <= '0;
            r_minor_span   <= '0;
            r_steps_left   <= '0;
            r_major_is_col <= 1'b0;
            r_row_dir_neg  <= 1'b0;
            r_col_dir_neg  <= 1'b0;
            r_line_active  <= 1'b0;
        end else if (i_accept) begin
            r_cur_row      <= n_cur_row;
            r_cur_col      <= n_cur_col;
            r_error_acc    <= n_error_acc;
            r_major_span   <= n_major_span;
            r_minor_span   <= n_minor_span;
            r_steps_left   <= n_steps_left;
            r_major_is_col <= n_major_is_col;
            r_row_dir_neg  <= n_row_dir_neg;
            r_col_dir_neg  <= n_col_dir_neg;
            r_line_active  <= n_line_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

`default_nettype wire

/* rtl/core/clr_pixel.sv */
// ----------------------------------------------------------------------------
// clr_pixel
// Frame clip test, frame index and color select; registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_pixel
    import clr_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_load,
    input  wire t_pixel                    i_pix,
    input  wire logic [COLOR_W-1:0]        i_color,
    output logic signed [COORD_W-1:0]      o_pixel_row,
    output logic signed [COORD_W-1:0]      o_pixel_col,
    output logic                           o_visible,
    output logic [INDEX_W-1:0]             o_pixel_index,
    output logic [COLOR_W-1:0]             o_color_out,
    output logic                           o_last_pixel,
    output logic                           o_idle
);

    localparam int RW = $clog2(FRAME_HEIGHT);   // bits of an in-frame row
    localparam int CW = $clog2(FRAME_WIDTH);    // bits of an in-frame column
    localparam logic signed [COORD_W:0] H_LIM = (COORD_W+1)'(FRAME_HEIGHT);
    localparam logic signed [COORD_W:0] W_LIM = (COORD_W+1)'(FRAME_WIDTH);

    logic        vis;
    logic [31:0] idx_full;

    logic signed [COORD_W-1:0] r_pixel_row, r_pixel_col;
    logic                      r_visible, r_last_pixel, r_idle;
    logic [INDEX_W-1:0]        r_pixel_index;
    logic [COLOR_W-1:0]        r_color_out;

    always_comb begin
        vis = !i_pix.idle
            && !i_pix.row[COORD_W-1] && ((COORD_W+1)'(i_pix.row) < H_LIM)
            && !i_pix.col[COORD_W-1] && ((COORD_W+1)'(i_pix.col) < W_LIM);
        idx_full = 32'(i_pix.row[RW-1:0]) * 32'(FRAME_WIDTH) + 32'(i_pix.col[CW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pixel_row   <= i_pix.row;
            r_pixel_col   <= i_pix.col;
            r_visible     <= vis;
            r_pixel_index <= vis ? idx_full[INDEX_W-1:0] : '0;
            r_color_out   <= vis ? i_color : '0;
            r_last_pixel  <= i_pix.last;
            r_idle        <= i_pix.idle;
        end
    end

    assign o_pixel_row   = r_pixel_row;
    assign o_pixel_col   = r_pixel_col;
    assign o_visible     = r_visible;
    assign o_pixel_index = r_pixel_index;
    assign o_color_out   = r_color_out;
    assign o_last_pixel  = r_last_pixel;
    assign o_idle        = r_idle;

endmodule

`default_nettype wire

/* rtl/core/clipped_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line walker with frame clipping, one pixel per beat.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. A load beat (cmd 0) sets up
// a line from the source to the destination point and returns the start
// pixel; each step beat (cmd 1) returns the next pixel of the line, with
// last_pixel set on the final one. A step with no line in progress returns a
// beat with idle set and all other fields zero. Pixels outside the frame
// carry their coordinates but have visible, pixel_index and color_out at
// zero. One beat is taken per clock unless the result side stalls; each
// pixel passes the walk register and the result register. The step unit
// sets the rate: error add, compare, subtract and coordinate update are
// combinational; frame test, index multiply and color select form the next
// stage. line_color may only be written while no beats are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic [COLOR_W-1:0]        i_cfg_wdata,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_cmd,
    input  wire logic signed [COORD_W-1:0] i_src_row,
    input  wire logic signed [COORD_W-1:0] i_src_col,
    input  wire logic signed [COORD_W-1:0] i_dst_row,
    input  wire logic signed [COORD_W-1:0] i_dst_col,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [COORD_W-1:0]      o_pixel_row,
    output logic signed [COORD_W-1:0]      o_pixel_col,
    output logic                           o_visible,
    output logic [INDEX_W-1:0]             o_pixel_index,
    output logic [COLOR_W-1:0]             o_color_out,
    output logic                           o_last_pixel,
    output logic                           o_idle
);

    logic [COLOR_W-1:0] r_line_color;
    logic               r_s1_valid, n_s1_valid;   // walk stage holds a pixel
    logic               r_out_valid, n_out_valid; // result register holds a beat

    logic   in_acc;     // input beat taken
    logic   out_take;   // result register can load
    logic   s1_adv;     // pixel moves from walk stage to result register
    t_pixel pix;

    // Two-stage pipe; ready chains back from the result side.
    always_comb begin
        out_take    = !r_out_valid || i_out_ready;
        s1_adv      = r_s1_valid && out_take;
        o_in_ready  = !r_s1_valid || out_take;
        in_acc      = i_in_valid && o_in_ready;
        n_s1_valid  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : r_s1_valid);
        n_out_valid = s1_adv ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_color <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_line_color <= i_cfg_wdata;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Line state and step unit.
    clr_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_acc),
        .i_cmd     (i_cmd),
        .i_src_row (i_src_row),
        .i_src_col (i_src_col),
        .i_dst_row (i_dst_row),
        .i_dst_col (i_dst_col),
        .o_pix     (pix)
    );

    // Clip, index and color; result register.
    clr_pixel #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_pixel (
        .i_clk         (i_clk),
        .i_load        (s1_adv),
        .i_pix         (pix),
        .i_color       (r_line_color),
        .o_pixel_row   (o_pixel_row),
        .o_pixel_col   (o_pixel_col),
        .o_visible     (o_visible),
        .o_pixel_index (o_pixel_index),
        .o_color_out   (o_color_out),
        .o_last_pixel  (o_last_pixel),
        .o_idle        (o_idle)
    );

endmodule

`default_nettype wire

/* rtl/core/clr_checker.sv */
// ----------------------------------------------------------------------------
// clr_checker
// Port-level assertions for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_checker
    import clr_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic signed [COORD_W-1:0] o_pixel_row,
    input wire logic signed [COORD_W-1:0] o_pixel_col,
    input wire logic                      o_visible,
    input wire logic [INDEX_W-1:0]        o_pixel_index,
    input wire logic [COLOR_W-1:0]        o_color_out,
    input wire logic                      o_last_pixel,
    input wire logic                      o_idle
);

    // nothing comes out the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // an idle beat carries no pixel
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_idle) |->
            (!o_visible && !o_last_pixel && o_pixel_row == '0 && o_pixel_col == '0))
        else $error("idle beat with pixel content");

    // clipped pixels write nothing
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_visible) |-> (o_pixel_index == '0 && o_color_out == '0))
        else $error("clipped pixel with index or color");

    // visible pixels never have negative coordinates
    a_vis_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_visible) |-> (!o_pixel_row[COORD_W-1] && !o_pixel_col[COORD_W-1]))
        else $error("visible pixel with negative coordinate");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_pixel_index) && $stable(o_last_pixel)))
        else $error("stalled result beat changed");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_row   (o_pixel_row),
    .o_pixel_col   (o_pixel_col),
    .o_visible     (o_visible),
    .o_pixel_index (o_pixel_index),
    .o_color_out   (o_color_out),
    .o_last_pixel  (o_last_pixel),
    .o_idle        (o_idle)
);

`default_nettype wire
